>>> hw/rtl/wsts_pkg.sv
// Package for the weighted server task scheduler: widths, word types, command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wsts_pkg;
   localparam int MaxServersDef = 64;
   localparam int WeightBitsDef = 20;
   localparam int TimeBitsDef   = 48;
   localparam int SlotBits      = 6;
   localparam int DurBits       = 20;
   localparam int WeightInBits  = 20;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TASK = 1'b1;

   typedef struct packed {
      logic                    op;
      logic [SlotBits-1:0]     server_slot;
      logic [WeightInBits-1:0] server_weight;
      logic [DurBits-1:0]      duration;
   } req_word_type;

   typedef struct packed {
      logic [SlotBits-1:0] assigned_server;
      logic                no_server;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request word
      logic push_load;  // push loaded server into free pool
      logic lift;       // lift now_time, advance task_number
      logic rel_start;  // reset busy scan index
      logic rel_step;   // examine one busy entry
      logic min_start;  // reset earliest-release scan
      logic min_step;   // examine one busy entry for earliest
      logic jump;       // now_time = earliest
      logic best_start; // reset free scan
      logic best_step;  // examine one free entry
      logic take;       // remove best, make busy, form result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_task;
      logic pool_empty;
      logic free_empty;
      logic rel_done;
      logic min_done;
      logic best_done;
      logic rd_ready;   // store read registers match current state
   } sts_type;
endpackage
`default_nettype wire

>>> hw/rtl/wsts_datapath.sv
// Datapath: free and busy stores, counters, time registers and scan units.
// Depends on wsts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsts_datapath #(
   parameter int MAX_SERVERS = wsts_pkg::MaxServersDef,
   parameter int WEIGHT_BITS = wsts_pkg::WeightBitsDef,
   parameter int TIME_BITS   = wsts_pkg::TimeBitsDef
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wsts_pkg::req_word_type    req_word,
   input  wsts_pkg::cmd_type         cmd,
   output wsts_pkg::sts_type         sts,
   output wsts_pkg::rsp_word_type    result
);
   localparam int IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CW = $clog2(MAX_SERVERS + 1);
   localparam int KW = WEIGHT_BITS + wsts_pkg::SlotBits;

   logic [KW-1:0]        free_mem [MAX_SERVERS];
   logic [KW-1:0]        bsrv_mem [MAX_SERVERS];
   logic [TIME_BITS-1:0] brel_mem [MAX_SERVERS];

   wsts_pkg::req_word_type req_ff;
   logic [CW-1:0]        free_cnt_ff, busy_cnt_ff, idx_ff, best_ff;
   logic [TIME_BITS-1:0] now_ff, tnum_ff, early_ff;
   logic [KW-1:0]        best_key_ff;
   logic                 any_ff;
   logic [KW-1:0]        fa_rd_ff, fb_rd_ff, ba_srv_ff, bb_srv_ff;
   logic [TIME_BITS-1:0] ba_rel_ff, bb_rel_ff;
   logic                 rdy_ff;

   wire [IW-1:0] idx    = idx_ff[IW-1:0];
   wire [IW-1:0] fc_m1  = IW'(free_cnt_ff - CW'(1));
   wire [IW-1:0] bc_m1  = IW'(busy_cnt_ff - CW'(1));
   wire [KW-1:0] ld_key = {WEIGHT_BITS'(req_ff.server_weight), req_ff.server_slot};
   wire                 due   = ba_rel_ff <= now_ff;

   assign sts.is_task    = req_ff.op == wsts_pkg::OP_TASK;
   assign sts.pool_empty = (free_cnt_ff == '0) && (busy_cnt_ff == '0);
   assign sts.free_empty = free_cnt_ff == '0;
   assign sts.rel_done   = idx_ff >= busy_cnt_ff;
   assign sts.min_done   = idx_ff >= busy_cnt_ff;
   assign sts.best_done  = idx_ff >= free_cnt_ff;
   assign sts.rd_ready   = rdy_ff;

   // registered store reads: scan entry and tail entry of each pool
   always_ff @(posedge clock) begin
      fa_rd_ff  <= free_mem[idx];
      fb_rd_ff  <= free_mem[fc_m1];
      ba_rel_ff <= brel_mem[idx];
      ba_srv_ff <= bsrv_mem[idx];
      bb_rel_ff <= brel_mem[bc_m1];
      bb_srv_ff <= bsrv_mem[bc_m1];
   end

   // control registers and scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         free_cnt_ff <= '0;
         busy_cnt_ff <= '0;
         now_ff      <= '0;
         tnum_ff     <= '0;
         idx_ff      <= '0;
         result      <= '0;
         rdy_ff      <= 1'b0;
      end else begin
         // read data is current once a command-free cycle has been registered
         rdy_ff <= cmd == '0;
         if (cmd.load) req_ff <= req_word;
         if (cmd.push_load && (free_cnt_ff + busy_cnt_ff < CW'(MAX_SERVERS))) begin
            free_mem[free_cnt_ff[IW-1:0]] <= ld_key;
            free_cnt_ff <= free_cnt_ff + CW'(1);
         end
         if (cmd.lift) begin
            if (tnum_ff > now_ff) now_ff <= tnum_ff;
            tnum_ff <= tnum_ff + TIME_BITS'(1);
            if ((free_cnt_ff == '0) && (busy_cnt_ff == '0)) begin
               result.assigned_server <= '0;
               result.no_server       <= 1'b1;
            end
         end
         if (cmd.rel_start || cmd.min_start || cmd.best_start) idx_ff <= '0;
         // one busy entry: move to free pool if due, fill the hole from the tail
         if (cmd.rel_step) begin
            if (due) begin
               free_mem[free_cnt_ff[IW-1:0]] <= ba_srv_ff;
               free_cnt_ff <= free_cnt_ff + CW'(1);
               brel_mem[idx] <= bb_rel_ff;
               bsrv_mem[idx] <= bb_srv_ff;
               busy_cnt_ff <= busy_cnt_ff - CW'(1);
            end else idx_ff <= idx_ff + CW'(1);
         end
         // earliest release search
         if (cmd.min_step) begin
            if (idx_ff == '0 || ba_rel_ff < early_ff) early_ff <= ba_rel_ff;
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.jump) now_ff <= early_ff;
         // least key search over free pool
         if (cmd.best_start) any_ff <= 1'b0;
         if (cmd.best_step) begin
            if (!any_ff || fa_rd_ff < best_key_ff) begin
               best_key_ff <= fa_rd_ff;
               best_ff     <= idx_ff;
            end
            any_ff <= 1'b1;
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.take) begin
            free_mem[best_ff[IW-1:0]] <= fb_rd_ff;
            free_cnt_ff <= free_cnt_ff - CW'(1);
            brel_mem[busy_cnt_ff[IW-1:0]] <=
               now_ff + TIME_BITS'(req_ff.duration);
            bsrv_mem[busy_cnt_ff[IW-1:0]] <= best_key_ff;
            busy_cnt_ff <= busy_cnt_ff + CW'(1);
            result.assigned_server <= best_key_ff[wsts_pkg::SlotBits-1:0];
            result.no_server       <= 1'b0;
         end
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (free_cnt_ff + busy_cnt_ff) <= CW'(MAX_SERVERS)) else $error("pool overflow");
   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> free_cnt_ff != '0) else $error("take from empty pool");
   a_time_mono: assert property (@(posedge clock) disable iff (reset)
      cmd.lift |=> now_ff >= $past(tnum_ff)) else $error("time not lifted");
endmodule
`default_nettype wire

>>> hw/rtl/wsts_ctrl.sv
// Controller state machine sequencing load, release, jump and selection.
// Depends on wsts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module wsts_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   input  wsts_pkg::sts_type   sts,
   output wsts_pkg::cmd_type   cmd
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001, S_DEC  = 8'b0000_0010, S_REL  = 8'b0000_0100,
      S_MIN  = 8'b0000_1000, S_REL2 = 8'b0001_0000, S_BEST = 8'b0010_0000,
      S_TAKE = 8'b0100_0000, S_OUT  = 8'b1000_0000
   } state_type;
   state_type state_ff, state_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   // next state and commands; scan states wait for fresh store reads
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: if (req_valid) begin cmd.load = 1'b1; state_in = S_DEC; end
         S_DEC: begin
            if (!sts.is_task) begin cmd.push_load = 1'b1; state_in = S_IDLE; end
            else begin
               cmd.lift = 1'b1; cmd.rel_start = 1'b1;
               state_in = sts.pool_empty ? S_OUT : S_REL;
            end
         end
         S_REL: if (sts.rd_ready) begin
            if (sts.rel_done) begin
               if (sts.free_empty) begin cmd.min_start = 1'b1; state_in = S_MIN; end
               else begin cmd.best_start = 1'b1; state_in = S_BEST; end
            end else cmd.rel_step = 1'b1;
         end
         S_MIN: if (sts.rd_ready) begin
            if (sts.min_done) begin
               cmd.jump = 1'b1; cmd.rel_start = 1'b1; state_in = S_REL2;
            end else cmd.min_step = 1'b1;
         end
         S_REL2: if (sts.rd_ready) begin
            if (sts.rel_done) begin
               cmd.best_start = 1'b1; state_in = S_BEST;
            end else cmd.rel_step = 1'b1;
         end
         S_BEST: if (sts.rd_ready) begin
            if (sts.best_done) state_in = S_TAKE; else cmd.best_step = 1'b1;
         end
         S_TAKE: if (sts.rd_ready) begin cmd.take = 1'b1; state_in = S_OUT; end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rel_step, cmd.min_step, cmd.best_step, cmd.take}))
      else $error("conflicting commands");
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
endmodule
`default_nettype wire

>>> hw/rtl/weighted_server_task_scheduler_top.sv
// Top level of the weighted server task scheduler: controller plus datapath.
// Depends on wsts_pkg, wsts_ctrl, wsts_datapath.
//
//  channel | ports                       | word
//  request | req_valid req_stall req_word | op, server_slot, server_weight, duration
//  result  | rsp_valid rsp_stall rsp_word | assigned_server, no_server
//
// A load passes through decode back to idle. A task runs a release pass over B busy
// and a least-key search over F free servers; each scan step waits for the registered
// store read. When none is free after the release pass, an earliest-release search and
// a second release pass run before it. A task with no server loaded goes to the result.
// Reset is synchronous and empties both pools and zeroes time.
// Requests stall while a word is in flight; a stalled result holds.
`timescale 1ns / 1ps
`default_nettype none
module weighted_server_task_scheduler_top #(
   parameter int MAX_SERVERS = wsts_pkg::MaxServersDef,
   parameter int WEIGHT_BITS = wsts_pkg::WeightBitsDef,
   parameter int TIME_BITS   = wsts_pkg::TimeBitsDef
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wsts_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output wsts_pkg::rsp_word_type rsp_word
);
   wsts_pkg::cmd_type cmd;
   wsts_pkg::sts_type sts;

   wsts_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   wsts_datapath #(
      .MAX_SERVERS(MAX_SERVERS), .WEIGHT_BITS(WEIGHT_BITS), .TIME_BITS(TIME_BITS)
   ) u_dp (
      .clock, .reset, .req_word, .cmd, .sts, .result(rsp_word)
   );
endmodule
`default_nettype wire

>>> tb/wsts_checker.sv
// Checker for the weighted server task scheduler: watches both channels,
// predicts each task's assigned server and compares. Depends on wsts_pkg.
`timescale 1ns / 1ps
module wsts_checker (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_stall,
   input  wsts_pkg::req_word_type req_word,
   input  wire                    rsp_valid,
   input  wire                    rsp_stall,
   input  wsts_pkg::rsp_word_type rsp_word,
   output int                     fail_count,
   output int                     pending
);
   import wsts_pkg::*;

   localparam int PoolSize = MaxServersDef;

   // predictor state: keys are {weight, slot}
   logic [25:0] free_keys [PoolSize];
   logic [25:0] busy_keys [PoolSize];
   logic [47:0] busy_until [PoolSize];
   int          n_free;
   int          n_busy;
   logic [47:0] clock_now;
   logic [47:0] next_arrival;
   rsp_word_type assign_q [$];

   // return busy servers due at clock_now to the free pool
   function automatic void free_due_servers();
      int i;
      i = 0;
      while (i < n_busy) begin
         if (busy_until[i] <= clock_now) begin
            if (n_free < PoolSize) begin
               free_keys[n_free] = busy_keys[i];
               n_free++;
            end
            n_busy--;
            busy_until[i] = busy_until[n_busy];
            busy_keys[i]  = busy_keys[n_busy];
         end else begin
            i++;
         end
      end
   endfunction

   function automatic void schedule_word(req_word_type w);
      rsp_word_type r;
      logic [47:0]  earliest;
      int           best;
      logic [25:0]  key;
      if (w.op == OP_LOAD) begin
         if (n_free + n_busy < PoolSize) begin
            free_keys[n_free] = {w.server_weight, w.server_slot};
            n_free++;
         end
         return;
      end
      if (next_arrival > clock_now) clock_now = next_arrival;
      next_arrival = next_arrival + 48'd1;
      if (n_free == 0 && n_busy == 0) begin
         r.assigned_server = '0;
         r.no_server = 1'b1;
         assign_q.push_back(r);
         return;
      end
      free_due_servers();
      // nothing free: jump to the earliest release
      if (n_free == 0) begin
         earliest = busy_until[0];
         for (int i = 1; i < n_busy; i++)
            if (busy_until[i] < earliest) earliest = busy_until[i];
         clock_now = earliest;
         free_due_servers();
      end
      best = 0;
      for (int i = 1; i < n_free; i++)
         if (free_keys[i] < free_keys[best]) best = i;
      key = free_keys[best];
      n_free--;
      free_keys[best] = free_keys[n_free];
      if (n_busy < PoolSize) begin
         busy_until[n_busy] = clock_now + 48'(w.duration);
         busy_keys[n_busy]  = key;
         n_busy++;
      end
      r.assigned_server = key[5:0];
      r.no_server = 1'b0;
      assign_q.push_back(r);
   endfunction

   assign pending = assign_q.size();

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (reset) begin
         n_free <= 0;
         n_busy <= 0;
         clock_now <= '0;
         next_arrival <= '0;
         fail_count <= 0;
         assign_q.delete();
      end else begin
         if (req_valid && !req_stall) schedule_word(req_word);
         // compare result words in order
         if (rsp_valid && !rsp_stall) begin
            if (assign_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result word %p", rsp_word);
               fail_count <= fail_count + 1;
            end else begin
               exp_word = assign_q.pop_front();
               if (exp_word !== rsp_word) begin
                  if (fail_count < 10)
                     $display("mismatch: expected server %0d flag %0b, got server %0d flag %0b",
                              exp_word.assigned_server, exp_word.no_server,
                              rsp_word.assigned_server, rsp_word.no_server);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> tb/tb_top.sv
// Testbench top for the weighted server task scheduler: clock, reset,
// stimulus and verdict. Depends on wsts_pkg, the block and wsts_checker.
`timescale 1ns / 1ps
module tb_top;
   import wsts_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending;
   int           loaded;
   int           rsp_wait;

   always #6 clock = ~clock;

   weighted_server_task_scheduler_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   wsts_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .fail_count(fail_count), .pending(pending)
   );

   // result side: the stall for each valid word is drawn at random with $urandom_range
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_wait  <= 0;
         rsp_stall <= 1'b0;
      end else if (rsp_valid && !rsp_stall) begin
         gap = $urandom_range(0, 4);
         rsp_wait  <= gap;
         rsp_stall <= (gap != 0);
      end else if (rsp_valid) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_stall <= (rsp_wait > 1);
      end
   end

   // send one word; unless no_gap is set, valid is first held low for a random gap
   task automatic send_word(logic op, logic [5:0] slot, logic [19:0] weight,
                            logic [19:0] dur, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{op: op, server_slot: slot, server_weight: weight, duration: dur};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_LOAD) loaded++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   function automatic logic [19:0] rand_dur();
      case ($urandom_range(0, 3))
         0: return 20'($urandom_range(0, 3));
         1: return 20'($urandom_range(0, 40));
         2: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   initial begin
      bit burst;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      loaded = 0;
      // tasks before any server is loaded
      send_word(OP_TASK, 6'd0, 20'd0, 20'd5, 0);
      send_word(OP_TASK, 6'h3F, 20'hFFFFF, 20'hFFFFF, 0);
      // extremes, repeated slot and equal keys
      send_word(OP_LOAD, 6'h3F, 20'hFFFFF, 20'd0, 0);
      send_word(OP_LOAD, 6'd0, 20'd0, 20'hFFFFF, 0);
      send_word(OP_LOAD, 6'd7, 20'd3, 20'd0, 0);
      send_word(OP_LOAD, 6'd7, 20'd3, 20'd0, 0);
      send_word(OP_TASK, 6'd0, 20'd0, 20'hFFFFF, 0);
      send_word(OP_TASK, 6'd0, 20'd0, 20'd0, 0);
      send_word(OP_TASK, 6'd0, 20'd0, 20'd2, 0);
      send_word(OP_TASK, 6'd0, 20'd0, 20'd1, 0);
      // two more tasks of duration 9
      send_word(OP_TASK, 6'd0, 20'd0, 20'd9, 0);
      send_word(OP_TASK, 6'd0, 20'd0, 20'd9, 0);
      // load after tasks
      send_word(OP_LOAD, 6'd5, 20'd1, 20'd0, 0);
      send_word(OP_TASK, 6'd0, 20'd0, 20'd4, 0);
      // random part: mostly tasks, loads until the pool fills, then ignored loads
      for (int n = 0; n < 850; n++) begin
         burst = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 99) < (loaded < 64 ? 30 : 5))
            send_word(OP_LOAD, 6'($urandom), ($urandom_range(0, 3) == 0) ?
                      20'($urandom_range(0, 3)) : 20'($urandom), rand_dur(), burst);
         else
            send_word(OP_TASK, 6'($urandom), 20'($urandom), rand_dur(), burst);
      end
      drop_valid();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // overall time limit
   initial begin
      #(12 * 2000000);
      $display("== FAIL ==");
      $finish;
   end
endmodule

>>> weighted_server_task_scheduler_top.f
hw/rtl/wsts_pkg.sv
hw/rtl/wsts_datapath.sv
hw/rtl/wsts_ctrl.sv
hw/rtl/weighted_server_task_scheduler_top.sv
tb/wsts_checker.sv
tb/tb_top.sv
